### sv/nnsa_pkg.sv
// ============================================================================
// nnsa_pkg
// Shared widths, register indexes and reset values for the nearest-neighbor
// scaling address generator.
// ============================================================================
`default_nettype none

package nnsa_pkg;

    localparam int CFG_W       = 12;
    localparam int ROW_W       = 11;
    localparam int COL_W       = 11;
    localparam int ADDR_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int PIXEL_BYTES = 3;
    localparam int ROW_ALIGN   = 4;
    localparam int DEF_MAX_DIM = 2048;

    localparam logic [CFG_W-1:0]  RST_SRC_WIDTH  = CFG_W'(1280);
    localparam logic [CFG_W-1:0]  RST_SRC_HEIGHT = CFG_W'(720);
    localparam logic [CFG_W-1:0]  RST_DST_WIDTH  = CFG_W'(1280);
    localparam logic [CFG_W-1:0]  RST_DST_HEIGHT = CFG_W'(720);
    localparam logic [ADDR_W-1:0] RST_SRC_BASE   = '0;
    localparam logic [ADDR_W-1:0] RST_DST_BASE   = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_SRC_BASE   = 3'd4,
        REG_DST_BASE   = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

### sv/nearest_neighbor_scale_addr.sv
// ============================================================================
// nearest_neighbor_scale_addr
// Pipelined source and destination address generator for nearest-neighbor
// scaling of 24-bit bitmaps with 4-byte aligned rows.
// ============================================================================
// Each input transaction on s_ carries the row and column of one destination
// pixel. Each output transaction on m_ returns the byte address of the source
// pixel to copy and the byte address where it is written, both modulo 2^32.
// Image sizes and base addresses are set through the cfg_ write channel,
// which is always ready; they must only change while no pixel is in flight.
// One transaction is accepted per clock while s_ready is high. Each one passes
// through the input register, the two restoring dividers that retire one
// quotient bit per stage, the multiply stage and the output register.
// A synchronous active-low reset empties the pipeline and loads the default
// image sizes of 1280 by 720 with zero base addresses.
// When the receiver stalls, the output register holds its transaction and a
// one-entry skid buffer catches the next one; s_ready then drops and the
// whole pipeline holds until the skid buffer drains. Nothing is lost.
// ============================================================================
`default_nettype none

module nearest_neighbor_scale_addr #(
    parameter int MAX_DIM = nnsa_pkg::DEF_MAX_DIM
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [nnsa_pkg::ADDR_W-1:0]    cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [nnsa_pkg::ROW_W-1:0]     s_dest_row,
    input  wire logic [nnsa_pkg::COL_W-1:0]     s_dest_col,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [nnsa_pkg::ADDR_W-1:0]         m_src_addr_out,
    output logic [nnsa_pkg::ADDR_W-1:0]         m_dst_addr_out
);

    import nnsa_pkg::*;

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int DIM_CAP = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
    localparam int EFF_W   = $clog2(DIM_CAP + 1);
    localparam int STR_W   = EFF_W + 2;
    localparam int QW      = ROW_W + EFF_W;
    localparam int NSTG    = QW + 2;

    typedef struct packed {
        logic [EFF_W-1:0]  rrem;
        logic [QW-1:0]     rdq;
        logic [EFF_W-1:0]  crem;
        logic [QW-1:0]     cdq;
        logic [ADDR_W-1:0] dacc;
        logic [ADDR_W-1:0] sprod;
        logic [ADDR_W-1:0] scol3;
    } pipe_t;

    logic [CFG_W-1:0]  src_width_reg;
    logic [CFG_W-1:0]  src_height_reg;
    logic [CFG_W-1:0]  dst_width_reg;
    logic [CFG_W-1:0]  dst_height_reg;
    logic [ADDR_W-1:0] src_base_reg;
    logic [ADDR_W-1:0] dst_base_reg;

    logic [EFF_W-1:0] eff_sw;
    logic [EFF_W-1:0] eff_sh;
    logic [EFF_W-1:0] eff_dw;
    logic [EFF_W-1:0] eff_dh;
    logic [STR_W-1:0] src_stride;
    logic [STR_W-1:0] dst_stride;

    pipe_t             pipe_reg [0:NSTG-1];
    logic [NSTG-1:0]   vld_reg;
    logic              en;

    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_src_reg;
    logic [ADDR_W-1:0] m_dst_reg;
    logic              skid_valid_reg;
    logic [ADDR_W-1:0] skid_src_reg;
    logic [ADDR_W-1:0] skid_dst_reg;
    logic [ADDR_W-1:0] fin_src_next;
    logic [ADDR_W-1:0] fin_dst_next;

    function automatic logic [EFF_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return EFF_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return EFF_W'(MAX_DIM);
        end
        return EFF_W'(v);
    endfunction

    function automatic logic [STR_W-1:0] row_stride(input logic [EFF_W-1:0] w);
        logic [STR_W-1:0] b;
        b = STR_W'(w) * STR_W'(PIXEL_BYTES) + STR_W'(ROW_ALIGN - 1);
        return b & ~STR_W'(ROW_ALIGN - 1);
    endfunction

    function automatic pipe_t div_step(input pipe_t p, input logic [EFF_W-1:0] dr,
                                       input logic [EFF_W-1:0] dc);
        pipe_t          q;
        logic [EFF_W:0] tr;
        logic [EFF_W:0] tc;
        logic           ger;
        logic           gec;
        q   = p;
        tr  = {p.rrem, p.rdq[QW-1]};
        tc  = {p.crem, p.cdq[QW-1]};
        ger = (tr >= {1'b0, dr});
        gec = (tc >= {1'b0, dc});
        q.rrem = ger ? EFF_W'(tr - {1'b0, dr}) : EFF_W'(tr);
        q.crem = gec ? EFF_W'(tc - {1'b0, dc}) : EFF_W'(tc);
        q.rdq  = {p.rdq[QW-2:0], ger};
        q.cdq  = {p.cdq[QW-2:0], gec};
        return q;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_width_reg  <= RST_DST_WIDTH;
            dst_height_reg <= RST_DST_HEIGHT;
            src_base_reg   <= RST_SRC_BASE;
            dst_base_reg   <= RST_DST_BASE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[CFG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_wdata[CFG_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[CFG_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_wdata[CFG_W-1:0];
                REG_SRC_BASE:   src_base_reg   <= cfg_wdata;
                REG_DST_BASE:   dst_base_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_sw     = eff_dim(src_width_reg);
        eff_sh     = eff_dim(src_height_reg);
        eff_dw     = eff_dim(dst_width_reg);
        eff_dh     = eff_dim(dst_height_reg);
        src_stride = row_stride(eff_sw);
        dst_stride = row_stride(eff_dw);
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0]          <= s_valid;
            pipe_reg[0].rrem    <= '0;
            pipe_reg[0].crem    <= '0;
            pipe_reg[0].rdq     <= QW'(s_dest_row) * QW'(eff_sh);
            pipe_reg[0].cdq     <= QW'(s_dest_col) * QW'(eff_sw);
            pipe_reg[0].dacc    <= ADDR_W'(s_dest_row) * ADDR_W'(dst_stride)
                                 + ADDR_W'(s_dest_col) * ADDR_W'(PIXEL_BYTES);
            pipe_reg[0].sprod   <= '0;
            pipe_reg[0].scol3   <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k]  <= vld_reg[k-1];
                pipe_reg[k] <= div_step(pipe_reg[k-1], eff_dh, eff_dw);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[QW+1] <= 1'b0;
        end else if (en) begin
            vld_reg[QW+1]        <= vld_reg[QW];
            pipe_reg[QW+1].rrem  <= pipe_reg[QW].rrem;
            pipe_reg[QW+1].rdq   <= pipe_reg[QW].rdq;
            pipe_reg[QW+1].crem  <= pipe_reg[QW].crem;
            pipe_reg[QW+1].cdq   <= pipe_reg[QW].cdq;
            pipe_reg[QW+1].dacc  <= pipe_reg[QW].dacc;
            pipe_reg[QW+1].sprod <= ADDR_W'(pipe_reg[QW].rdq) * ADDR_W'(src_stride);
            pipe_reg[QW+1].scol3 <= ADDR_W'(pipe_reg[QW].cdq) * ADDR_W'(PIXEL_BYTES);
        end
    end

    assign fin_src_next = src_base_reg + pipe_reg[QW+1].sprod + pipe_reg[QW+1].scol3;
    assign fin_dst_next = dst_base_reg + pipe_reg[QW+1].dacc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                m_src_reg      <= skid_src_reg;
                m_dst_reg      <= skid_dst_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[QW+1];
                m_src_reg   <= fin_src_next;
                m_dst_reg   <= fin_dst_next;
            end
        end else if (vld_reg[QW+1] && en) begin
            skid_valid_reg <= 1'b1;
            skid_src_reg   <= fin_src_next;
            skid_dst_reg   <= fin_dst_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_src_addr_out = m_src_reg;
    assign m_dst_addr_out = m_dst_reg;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid buffer holds a transaction while the output is empty");

    a_stall_holds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[QW+1] && !en) |=> vld_reg[QW+1])
        else $error("last pipeline stage dropped a transaction during a stall");

    a_skid_refills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && skid_valid_reg) |=> (m_valid && !skid_valid_reg))
        else $error("skid buffer did not move into the output register");
`endif

endmodule

`default_nettype wire
